@@ rtl/chlc_pkg.sv @@
package chlc_pkg;

	localparam logic [2:0] OP_CONNECT = 3'd0;
	localparam logic [2:0] OP_DISCONNECT = 3'd1;
	localparam logic [2:0] OP_RX_CHALLENGE = 3'd2;
	localparam logic [2:0] OP_RX_REJECTED = 3'd3;
	localparam logic [2:0] OP_RX_DATA = 3'd4;
	localparam logic [2:0] OP_RX_DISCONNECT = 3'd5;
	localparam logic [2:0] OP_TICK = 3'd6;

	localparam logic [2:0] MODE_DISCONNECTED = 3'd0;
	localparam logic [2:0] MODE_REQUESTING = 3'd1;
	localparam logic [2:0] MODE_RESPONDING = 3'd2;
	localparam logic [2:0] MODE_CONNECTED = 3'd3;
	localparam logic [2:0] MODE_DISCONNECTING = 3'd4;

	localparam logic [1:0] KIND_REQUEST = 2'd0;
	localparam logic [1:0] KIND_RESPONSE = 2'd1;
	localparam logic [1:0] KIND_DATA = 2'd2;
	localparam logic [1:0] KIND_DISCONNECT = 2'd3;

	localparam logic REG_SEND_INTERVAL = 1'b0;
	localparam logic REG_KEY_SEED = 1'b1;

	localparam logic [15:0] SEND_INTERVAL_RESET = 16'd200;
	localparam logic [7:0] FAREWELL_TRIES = 8'd10;

	localparam logic [63:0] KEY_GAMMA = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] KEY_MIX1 = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] KEY_MIX2 = 64'h94d049bb133111eb;

	// three 32x32 partial products per 64-bit multiply, two multiplies per key
	localparam logic [2:0] MUL_STEP_LAST = 3'd5;

	typedef struct packed {
		logic [2:0] op;
		logic [63:0] rx_challenge;
		logic [31:0] rx_sequence;
	} chlc_in_t;

	typedef struct packed {
		logic tx_valid;
		logic [1:0] tx_kind;
		logic [63:0] tx_word;
		logic [31:0] tx_seq;
		logic [31:0] tx_ack_number;
		logic [31:0] tx_elapsed;
		logic [2:0] link_status;
	} chlc_out_t;

	typedef struct packed {
		logic load_item;
		logic exec;
		logic mul_en;
		logic [2:0] mul_step;
		logic out_load;
	} chlc_cmd_t;

	typedef struct packed {
		logic need_key;
	} chlc_sts_t;

endpackage

@@ rtl/challenge_handshake_link_client.sv @@
// an accepted item is registered, then executed into a pending result; a connect
// that draws a key then takes six steps of one shared 32x32 multiplier
// the pending result moves to the output register once that is free; a new item
// is then taken while the finished result waits in the output register
// reset: asynchronous, active low; link disconnected, interval 200, seed zero
module challenge_handshake_link_client (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input chlc_pkg::chlc_in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output chlc_pkg::chlc_out_t out_data,
	input logic cfg_we,
	input logic cfg_index,
	input logic [63:0] cfg_data
);
	import chlc_pkg::*;

	chlc_cmd_t cmd;
	chlc_sts_t sts;

	chlc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts(sts),
		.cmd(cmd)
	);

	chlc_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.in_data(in_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_data(out_data)
	);

endmodule

@@ rtl/chlc_ctrl.sv @@
module chlc_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input chlc_pkg::chlc_sts_t sts,
	output chlc_pkg::chlc_cmd_t cmd
);
	import chlc_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_MUL = 2'd2;
	localparam logic [1:0] ST_OUT = 2'd3;

	logic [1:0] state_q, state_nx;
	logic [2:0] step_q, step_nx;
	logic out_valid_q, out_valid_nx;
	logic slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_nx = state_q;
		step_nx = step_q;
		cmd = '0;
		cmd.mul_step = step_q;
		out_valid_nx = out_valid_q && !out_ready;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_nx = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				step_nx = '0;
				state_nx = sts.need_key ? ST_MUL : ST_OUT;
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				if (step_q == MUL_STEP_LAST) begin
					state_nx = ST_OUT;
				end else begin
					step_nx = step_q + 3'd1;
				end
			end
			ST_OUT: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					out_valid_nx = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			step_q <= step_nx;
			out_valid_q <= out_valid_nx;
		end
	end

	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_EXEC)
		else $error("accepted item did not enter exec");

	a_mul_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL && step_q == MUL_STEP_LAST |=> state_q == ST_OUT)
		else $error("key multiply did not finish into output");

	a_out_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("result load lost");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= MUL_STEP_LAST)
		else $error("multiply step out of range");

	a_no_load_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_item |-> !cmd.exec && !cmd.mul_en && !cmd.out_load)
		else $error("item load overlaps other work");

endmodule

@@ rtl/chlc_dp.sv @@
module chlc_dp (
	input logic clk,
	input logic arst_n,
	input chlc_pkg::chlc_cmd_t cmd,
	output chlc_pkg::chlc_sts_t sts,
	input chlc_pkg::chlc_in_t in_data,
	input logic cfg_we,
	input logic cfg_index,
	input logic [63:0] cfg_data,
	output chlc_pkg::chlc_out_t out_data
);
	import chlc_pkg::*;

	// item held for processing
	logic [2:0] op_q;
	logic [63:0] chal_q;
	logic [31:0] rseq_q;

	// link state
	logic [2:0] mode_q, mode_nx;
	logic [15:0] interval_q;
	logic [63:0] rng_q, rng_nx;
	logic [63:0] key_q;
	logic [63:0] held_chal_q, held_chal_nx;
	logic [31:0] oseq_q, oseq_nx;
	logic [31:0] ack_q, ack_nx;
	logic [7:0] fare_q, fare_nx;
	logic [31:0] tss_q, tss_nx, tss_inc;
	logic [31:0] tsr_q, tsr_nx, tsr_inc;

	// key generation
	logic [63:0] z_q;
	logic [63:0] acc_q, acc_nx;
	logic round;
	logic [2:0] phase;
	logic [63:0] mconst;
	logic [31:0] ma, mb;
	logic [63:0] prod;

	chlc_out_t res, pend_q, out_q;
	logic is_rx;

	assign sts.need_key = (op_q == OP_CONNECT) && (mode_q == MODE_DISCONNECTED);
	assign rng_nx = rng_q + KEY_GAMMA;
	assign tss_inc = (&tss_q) ? tss_q : tss_q + 32'd1;
	assign tsr_inc = (&tsr_q) ? tsr_q : tsr_q + 32'd1;
	assign is_rx = (op_q == OP_RX_CHALLENGE) || (op_q == OP_RX_REJECTED) ||
		(op_q == OP_RX_DATA) || (op_q == OP_RX_DISCONNECT);

	always_comb begin
		mode_nx = mode_q;
		held_chal_nx = held_chal_q;
		oseq_nx = oseq_q;
		ack_nx = ack_q;
		fare_nx = fare_q;
		tss_nx = tss_q;
		tsr_nx = tsr_q;
		res = '0;
		if (op_q == OP_CONNECT) begin
			if (mode_q == MODE_DISCONNECTED) begin
				mode_nx = MODE_REQUESTING;
			end
		end else if (op_q == OP_DISCONNECT) begin
			if (mode_q != MODE_DISCONNECTED) begin
				mode_nx = MODE_DISCONNECTING;
				fare_nx = '0;
			end
		end else if (is_rx) begin
			if (mode_q != MODE_DISCONNECTED) begin
				tsr_nx = '0;
				case (op_q)
					OP_RX_CHALLENGE: begin
						if (mode_q == MODE_REQUESTING) begin
							mode_nx = MODE_RESPONDING;
							held_chal_nx = chal_q;
						end
					end
					OP_RX_REJECTED: begin
						if (mode_q == MODE_REQUESTING || mode_q == MODE_RESPONDING) begin
							mode_nx = MODE_DISCONNECTED;
						end
					end
					OP_RX_DATA: begin
						if (mode_q == MODE_RESPONDING || mode_q == MODE_CONNECTED) begin
							mode_nx = MODE_CONNECTED;
							ack_nx = rseq_q;
						end
					end
					default: begin
						if (mode_q == MODE_CONNECTED) begin
							mode_nx = MODE_DISCONNECTED;
						end
					end
				endcase
			end
		end else if (op_q == OP_TICK) begin
			tss_nx = tss_inc;
			tsr_nx = tsr_inc;
			// an interval of zero acts as one, since the bumped count is never zero
			if (mode_q != MODE_DISCONNECTED && tss_inc >= {16'd0, interval_q}) begin
				tss_nx = '0;
				case (mode_q)
					MODE_REQUESTING: begin
						res.tx_valid = 1'b1;
						res.tx_kind = KIND_REQUEST;
						res.tx_word = key_q;
					end
					MODE_RESPONDING: begin
						res.tx_valid = 1'b1;
						res.tx_kind = KIND_RESPONSE;
						res.tx_word = key_q ^ held_chal_q;
					end
					MODE_CONNECTED: begin
						res.tx_valid = 1'b1;
						res.tx_kind = KIND_DATA;
						res.tx_seq = oseq_q;
						res.tx_ack_number = ack_q;
						res.tx_elapsed = tsr_inc;
						oseq_nx = oseq_q + 32'd1;
					end
					default: begin
						if (fare_q >= FAREWELL_TRIES) begin
							// farewells used up: go idle, send counter keeps its count
							mode_nx = MODE_DISCONNECTED;
							tss_nx = tss_inc;
						end else begin
							res.tx_valid = 1'b1;
							res.tx_kind = KIND_DISCONNECT;
							fare_nx = fare_q + 8'd1;
						end
					end
				endcase
			end
		end
		res.link_status = mode_nx;
	end

	// one shared 32x32 multiplier; 64-bit product mod 2^64 from three partials
	assign round = (cmd.mul_step >= 3'd3);
	assign phase = round ? cmd.mul_step - 3'd3 : cmd.mul_step;
	assign mconst = round ? KEY_MIX2 : KEY_MIX1;

	always_comb begin
		ma = z_q[31:0];
		mb = mconst[31:0];
		if (phase == 3'd1) begin
			mb = mconst[63:32];
		end else if (phase == 3'd2) begin
			ma = z_q[63:32];
		end
	end

	assign prod = {32'd0, ma} * {32'd0, mb};

	always_comb begin
		if (phase == 3'd0) begin
			acc_nx = prod;
		end else begin
			acc_nx = {acc_q[63:32] + prod[31:0], acc_q[31:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q <= in_data.op;
			chal_q <= in_data.rx_challenge;
			rseq_q <= in_data.rx_sequence;
		end
		if (cmd.exec) begin
			pend_q <= res;
			if (sts.need_key) begin
				z_q <= rng_nx ^ (rng_nx >> 30);
			end
		end
		if (cmd.mul_en) begin
			acc_q <= acc_nx;
			if (phase == 3'd2 && !round) begin
				z_q <= acc_nx ^ (acc_nx >> 27);
			end
		end
		if (cmd.out_load) begin
			out_q <= pend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_DISCONNECTED;
			interval_q <= SEND_INTERVAL_RESET;
			rng_q <= '0;
			key_q <= '0;
			held_chal_q <= '0;
			oseq_q <= '0;
			ack_q <= '0;
			fare_q <= '0;
			tss_q <= '1;
			tsr_q <= '0;
		end else begin
			if (cmd.exec) begin
				mode_q <= mode_nx;
				held_chal_q <= held_chal_nx;
				oseq_q <= oseq_nx;
				ack_q <= ack_nx;
				fare_q <= fare_nx;
				tss_q <= tss_nx;
				tsr_q <= tsr_nx;
				if (sts.need_key) begin
					rng_q <= rng_nx;
				end
			end
			if (cmd.mul_en && phase == 3'd2 && round) begin
				key_q <= acc_nx ^ (acc_nx >> 31);
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_SEND_INTERVAL: interval_q <= cfg_data[15:0];
					REG_KEY_SEED: rng_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	assign out_data = out_q;

endmodule

@@ test/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import chlc_pkg::*;

	localparam logic [2:0] OP_UNUSED = 3'd7;
	localparam int EVENT_TARGET = 1100;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_LIMIT = 5000;

	class link_scoreboard;
		logic [15:0] send_gap;
		logic [63:0] rng;
		logic [2:0] mode;
		logic [63:0] key;
		logic [63:0] challenge;
		logic [31:0] out_seq;
		logic [31:0] ack;
		logic [7:0] farewells;
		logic [31:0] since_tx;
		logic [31:0] since_rx;
		chlc_out_t expected_tx[$];
		int errors;
		int checked;
		int sent_kind[4];

		function new();
			send_gap = SEND_INTERVAL_RESET;
			rng = '0;
			mode = MODE_DISCONNECTED;
			key = '0;
			challenge = '0;
			out_seq = '0;
			ack = '0;
			farewells = '0;
			since_tx = '1;
			since_rx = '0;
			errors = 0;
			checked = 0;
			foreach (sent_kind[i]) sent_kind[i] = 0;
		endfunction

		function void write_reg(logic idx, logic [63:0] data);
			if (idx == REG_SEND_INTERVAL) send_gap = data[15:0];
			else rng = data;
		endfunction

		// splitmix64 step
		function logic [63:0] draw_key();
			logic [63:0] z;
			rng = rng + KEY_GAMMA;
			z = rng;
			z = (z ^ (z >> 30)) * KEY_MIX1;
			z = (z ^ (z >> 27)) * KEY_MIX2;
			return z ^ (z >> 31);
		endfunction

		function void note_event(chlc_in_t ev);
			chlc_out_t r;
			r = '0;
			case (ev.op)
			OP_CONNECT: if (mode == MODE_DISCONNECTED) begin
				mode = MODE_REQUESTING;
				key = draw_key();
			end
			OP_DISCONNECT: if (mode != MODE_DISCONNECTED) begin
				mode = MODE_DISCONNECTING;
				farewells = '0;
			end
			OP_RX_CHALLENGE, OP_RX_REJECTED, OP_RX_DATA,
			OP_RX_DISCONNECT: if (mode != MODE_DISCONNECTED) begin
				since_rx = '0;
				case (ev.op)
				OP_RX_CHALLENGE: if (mode == MODE_REQUESTING) begin
					mode = MODE_RESPONDING;
					challenge = ev.rx_challenge;
				end
				OP_RX_REJECTED: begin
					if (mode == MODE_REQUESTING || mode == MODE_RESPONDING)
						mode = MODE_DISCONNECTED;
				end
				OP_RX_DATA: begin
					if (mode == MODE_RESPONDING) mode = MODE_CONNECTED;
					if (mode == MODE_CONNECTED) ack = ev.rx_sequence;
				end
				default: if (mode == MODE_CONNECTED) mode = MODE_DISCONNECTED;
				endcase
			end
			OP_TICK: begin
				if (since_tx != '1) since_tx++;
				if (since_rx != '1) since_rx++;
				if (mode != MODE_DISCONNECTED && since_tx >= {16'd0, send_gap}) begin
					// farewell done: go idle without a transfer, send counter kept
					if (mode == MODE_DISCONNECTING && farewells >= FAREWELL_TRIES) begin
						mode = MODE_DISCONNECTED;
					end else begin
						r.tx_valid = 1'b1;
						case (mode)
						MODE_REQUESTING: begin
							r.tx_kind = KIND_REQUEST;
							r.tx_word = key;
						end
						MODE_RESPONDING: begin
							r.tx_kind = KIND_RESPONSE;
							r.tx_word = key ^ challenge;
						end
						MODE_CONNECTED: begin
							r.tx_kind = KIND_DATA;
							r.tx_seq = out_seq;
							r.tx_ack_number = ack;
							r.tx_elapsed = since_rx;
							out_seq++;
						end
						default: begin
							r.tx_kind = KIND_DISCONNECT;
							farewells++;
						end
						endcase
						since_tx = '0;
						sent_kind[r.tx_kind]++;
					end
				end
			end
			default: ;
			endcase
			r.link_status = mode;
			expected_tx.push_back(r);
		endfunction

		function bit field_ok(string name, logic [63:0] want, logic [63:0] got);
			if (want === got) return 1'b1;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			return 1'b0;
		endfunction

		function void check_result(chlc_out_t act);
			chlc_out_t want;
			bit ok;
			if (expected_tx.size() == 0) begin
				$display("%0t: result with nothing expected, expected none, actual %h",
					$time, act);
				errors++;
				return;
			end
			want = expected_tx.pop_front();
			ok = field_ok("tx_valid", 64'(want.tx_valid), 64'(act.tx_valid));
			ok = field_ok("tx_kind", 64'(want.tx_kind), 64'(act.tx_kind)) && ok;
			ok = field_ok("tx_word", want.tx_word, act.tx_word) && ok;
			ok = field_ok("tx_seq", 64'(want.tx_seq), 64'(act.tx_seq)) && ok;
			ok = field_ok("tx_ack_number", 64'(want.tx_ack_number),
				64'(act.tx_ack_number)) && ok;
			ok = field_ok("tx_elapsed", 64'(want.tx_elapsed), 64'(act.tx_elapsed)) && ok;
			ok = field_ok("link_status", 64'(want.link_status), 64'(act.link_status)) && ok;
			if (!ok) errors++;
			checked++;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid = 1'b0;
	logic in_ready;
	chlc_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	chlc_out_t out_data;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [63:0] cfg_data = '0;

	link_scoreboard board = new();
	int events_sent = 0;
	int results_seen = 0;
	int settings = 0;
	int cycles = 0;
	logic [15:0] cur_interval = SEND_INTERVAL_RESET;
	bit hold_rx = 1'b0;
	bit hold_done = 1'b0;

	challenge_handshake_link_client u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic chlc_in_t make_event(logic [2:0] op);
		chlc_in_t ev;
		ev.op = op;
		ev.rx_challenge = rand64();
		ev.rx_sequence = $urandom;
		return ev;
	endfunction

	task automatic push_event(chlc_in_t ev);
		// no sender gaps in this window
		while (!(events_sent >= 300 && events_sent < 500) && $urandom_range(99) < 10) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= ev;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.note_event(ev);
		events_sent++;
	endtask

	task automatic push_op(logic [2:0] op);
		push_event(make_event(op));
	endtask

	task automatic tick_some(int n);
		repeat (n) push_op(OP_TICK);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (board.expected_tx.size() != 0) @(posedge clk);
		// covers a key-drawing connect still in flight
		repeat (10) @(posedge clk);
	endtask

	task automatic write_regs(logic [15:0] send_gap, logic [63:0] seed);
		logic [63:0] noise;
		logic [63:0] gap_word;
		noise = rand64();
		gap_word = {noise[47:0], send_gap};
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= REG_SEND_INTERVAL;
		cfg_data <= gap_word;
		@(posedge clk);
		board.write_reg(REG_SEND_INTERVAL, gap_word);
		cfg_index <= REG_KEY_SEED;
		cfg_data <= seed;
		@(posedge clk);
		board.write_reg(REG_KEY_SEED, seed);
		cfg_we <= 1'b0;
		cur_interval = send_gap;
		settings++;
	endtask

	task automatic farewell_ticks();
		int per_send;
		int n;
		per_send = (cur_interval == 0) ? 1 : int'(cur_interval);
		n = per_send * (FAREWELL_TRIES + 1) + 1;
		tick_some((n > 60) ? 60 : n);
	endtask

	task automatic run_session();
		push_op(OP_CONNECT);
		tick_some($urandom_range(1, 4));
		if ($urandom_range(9) == 0) begin
			push_op(OP_RX_REJECTED);
			return;
		end
		push_op(OP_RX_CHALLENGE);
		tick_some($urandom_range(0, 4));
		if ($urandom_range(9) == 0) begin
			push_op(OP_RX_REJECTED);
			return;
		end
		push_op(OP_RX_DATA);
		repeat ($urandom_range(6, 30)) begin
			if ($urandom_range(2) == 0) push_op(OP_RX_DATA);
			else push_op(OP_TICK);
		end
		case ($urandom_range(2))
		0: begin
			push_op(OP_DISCONNECT);
			farewell_ticks();
		end
		1: push_op(OP_RX_DISCONNECT);
		default: begin
			// restart the farewell count part way through
			push_op(OP_DISCONNECT);
			tick_some($urandom_range(1, 5));
			push_op(OP_DISCONNECT);
			farewell_ticks();
		end
		endcase
	endtask

	initial begin : rx_side
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready) begin
				board.check_result(out_data);
				results_seen++;
			end
			if (hold_rx && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (results_seen >= 300 && results_seen < 500) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= 10);
			end
		end
	end

	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb failed");
		$finish;
	end

	initial begin : stimulus
		chlc_in_t ev;
		logic [15:0] send_gap;
		logic [63:0] seed;
		int phase;
		int tail;
		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: first tick sends since the send counter starts saturated
		push_op(OP_UNUSED);
		push_op(OP_RX_DATA);
		push_op(OP_CONNECT);
		push_op(OP_CONNECT);
		push_op(OP_TICK);
		push_op(OP_TICK);

		// zero interval sends on every tick
		write_regs('0, '1);
		push_op(OP_RX_REJECTED);
		push_op(OP_CONNECT);
		ev = make_event(OP_RX_CHALLENGE);
		ev.rx_challenge = '1;
		push_event(ev);
		push_op(OP_TICK);
		ev = make_event(OP_RX_DATA);
		ev.rx_sequence = '1;
		push_event(ev);
		push_op(OP_TICK);
		push_op(OP_RX_DISCONNECT);
		push_op(OP_CONNECT);
		ev = make_event(OP_RX_CHALLENGE);
		ev.rx_challenge = '0;
		push_event(ev);
		ev = make_event(OP_RX_DATA);
		ev.rx_sequence = '0;
		push_event(ev);
		push_op(OP_DISCONNECT);
		push_op(OP_TICK);
		push_op(OP_DISCONNECT);
		tick_some(FAREWELL_TRIES + 1);

		phase = 0;
		while (events_sent < EVENT_TARGET) begin
			case ($urandom_range(9))
			0: send_gap = '0;
			1: send_gap = '1;
			2: send_gap = 16'($urandom_range(4, 40));
			default: send_gap = 16'($urandom_range(1, 3));
			endcase
			if (phase == 1) send_gap = '1;
			case ($urandom_range(7))
			0: seed = '0;
			1: seed = '1;
			default: seed = rand64();
			endcase
			write_regs(send_gap, seed);
			// receiver holds off while sessions keep coming
			if (phase == 2) hold_rx = 1'b1;
			repeat ($urandom_range(3, 6)) begin
				if (events_sent < EVENT_TARGET) begin
					if ($urandom_range(99) < 85) begin
						run_session();
					end else begin
						repeat ($urandom_range(4, 12)) push_op(3'($urandom_range(7)));
					end
				end
			end
			phase++;
		end

		in_valid <= 1'b0;
		tail = 0;
		while (board.expected_tx.size() != 0 && tail < TAIL_LIMIT) begin
			@(posedge clk);
			tail++;
		end
		repeat (20) @(posedge clk);
		if (board.expected_tx.size() != 0)
			$display("%0t: %0d results never arrived", $time, board.expected_tx.size());

		$display("covered %0d events under %0d register settings, %0d results checked",
			events_sent, settings, board.checked);
		$display("transfers out: %0d request, %0d response, %0d data, %0d disconnect",
			board.sent_kind[KIND_REQUEST], board.sent_kind[KIND_RESPONSE],
			board.sent_kind[KIND_DATA], board.sent_kind[KIND_DISCONNECT]);
		if (board.errors == 0 && board.expected_tx.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end
endmodule
